/* rtl/keyed_aggregation_hash_table_core_defines.svh */
// Assertion macros used by the keyed aggregation table checker
`ifndef KEYED_AGGREGATION_HASH_TABLE_CORE_DEFINES_SVH
`define KEYED_AGGREGATION_HASH_TABLE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KAHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kaht: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define KAHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kaht: next-cycle check failed");

`endif

/* rtl/kaht_pkg.sv */
// Package: types, constants and codes of the keyed aggregation table
`timescale 1ns / 1ps
package kaht_pkg;

    localparam int NUM_CPUS     = 4;
    localparam int CPU_W        = 2;
    localparam int NUM_BUCKETS  = 256;
    localparam int BKT_W        = 8;
    localparam int RECORD_WORDS = 4096;
    localparam int REC_W        = 12;
    localparam int KEY_BYTES    = 8;
    localparam int HEAD_DEPTH   = NUM_CPUS * NUM_BUCKETS;
    localparam int HEAD_AW      = CPU_W + BKT_W;
    localparam int STORE_DEPTH  = NUM_CPUS * RECORD_WORDS;
    localparam int STORE_AW     = CPU_W + REC_W;
    localparam int CNT_W        = HEAD_AW;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
    localparam int          FNV_PRIME_SH = 40;

    localparam logic [3:0] AGG_COUNT = 4'd0;
    localparam logic [3:0] AGG_SUM   = 4'd1;
    localparam logic [3:0] AGG_AVG   = 4'd2;
    localparam logic [3:0] AGG_MIN   = 4'd3;
    localparam logic [3:0] AGG_MAX   = 4'd4;
    localparam logic [3:0] AGG_STD   = 4'd5;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_CREATED = 2'd1,
        ST_DROPPED = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         cpu_index;
        logic [31:0]        agg_id;
        logic [63:0]        key_bytes;
        logic [3:0]         key_length;
        logic signed [63:0] sample_value;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [11:0] record_index;
        logic [63:0] first_accumulator;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_SQ,
        OP_HASH,
        OP_HEAD_RD,
        OP_LINK_HEAD,
        OP_HDR_RD,
        OP_HDR_TAKE,
        OP_KEY_RD,
        OP_NEXT,
        OP_VAL_RD,
        OP_VAL_WR,
        OP_LINK_PREV,
        OP_NEW_WR
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    cnt_clr;
        logic    emit;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic kw;
        logic id_match;
        logic key_eq;
        logic link_valid;
        logic oversize;
        logic full;
        logic sq_last;
        logic hash_last;
        logic val_last;
        logic new_last;
        logic clr_last;
    } t_dp_stat;

endpackage

/* rtl/kaht_dp.sv */
// Datapath: hash unit, squarer, chain walk registers, bucket and record memories
`timescale 1ns / 1ps
module kaht_dp
    import kaht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_strobe,
    output t_out_word o_out
);

    logic [12:0]         r_head_mem [HEAD_DEPTH];
    logic [63:0]         r_store    [STORE_DEPTH];
    logic [12:0]         r_head_rd;
    logic [63:0]         r_rdata;
    logic [12:0]         r_wp [NUM_CPUS];

    logic [CNT_W-1:0]    r_cnt;
    logic [CPU_W-1:0]    r_cpu;
    logic [31:0]         r_id;
    logic [63:0]         r_key;
    logic signed [63:0]  r_val;
    logic [63:0]         r_mag;
    logic [63:0]         r_hash;
    logic [127:0]        r_sq;
    logic [31:0]         r_link;
    logic [63:0]         r_hdr;
    logic [REC_W-1:0]    r_prev;
    logic                r_prev_head;
    logic [REC_W-1:0]    r_rec;
    logic [63:0]         r_acc0;
    logic                r_carry;

    logic [3:0]          agg;
    logic                kw;
    logic [2:0]          vw;
    logic [2:0]          need;
    logic [3:0]          nkey;
    logic [63:0]         kmask;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         prod;
    logic [63:0]         hx;
    logic [63:0]         hmul;
    logic [63:0]         new_val;
    logic [64:0]         lo_sum;
    logic [63:0]         new_word;
    logic [2:0]          nk;
    logic [63:0]         acc_now;
    logic [STORE_AW-1:0] s_addr;
    logic                s_we;
    logic [63:0]         s_wd;
    logic [HEAD_AW-1:0]  h_addr;
    logic                h_we;
    logic [12:0]         h_wd;
    logic [12:0]         wp_cur;
    logic [13:0]         wp_end;
    logic [32:0]         r_end;

    assign agg    = r_id[31:28];
    assign kw     = r_id[16];
    assign vw     = (agg == AGG_AVG) ? 3'd2 : (agg == AGG_STD) ? 3'd4 : 3'd1;
    assign need   = 3'd1 + {2'b0, kw} + vw;
    assign wp_cur = r_wp[r_cpu];
    assign wp_end = {1'b0, wp_cur} + {11'b0, need};
    assign r_end  = {2'b0, r_link[30:0]} + {30'b0, need};
    assign nkey   = (i_in.key_length > 4'd8) ? 4'd8 : i_in.key_length;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            kmask[8*i +: 8] = {8{(4'(i) < nkey) && i_in.agg_id[16]}};
        end
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mul_a = r_mag[31:0];  mul_b = r_mag[31:0];  end
            2'd1:    begin mul_a = r_mag[31:0];  mul_b = r_mag[63:32]; end
            default: begin mul_a = r_mag[63:32]; mul_b = r_mag[63:32]; end
        endcase
    end
    assign prod = {32'b0, mul_a} * {32'b0, mul_b};

    assign hx   = r_hash ^ {56'b0, r_key[8*r_cnt[2:0] +: 8]};
    assign hmul = hx * {55'b0, FNV_PRIME_LO};

    assign lo_sum = {1'b0, r_rdata} + {1'b0, r_sq[63:0]};

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                case (agg)
                    AGG_COUNT: new_val = r_rdata + 64'd1;
                    AGG_MIN:   new_val = (r_val < $signed(r_rdata)) ? r_val : r_rdata;
                    AGG_MAX:   new_val = (r_val > $signed(r_rdata)) ? r_val : r_rdata;
                    default:   new_val = r_rdata + r_val;
                endcase
            end
            2'd1:    new_val = r_rdata + 64'd1;
            2'd2:    new_val = lo_sum[63:0];
            default: new_val = r_rdata + r_sq[127:64] + {63'b0, r_carry};
        endcase
    end

    assign nk = r_cnt[2:0] - 3'd1 - {2'b0, kw};
    always_comb begin
        if (r_cnt[2:0] == 3'd0) begin
            new_word = {r_id, 32'b0};
        end else if (kw && r_cnt[2:0] == 3'd1) begin
            new_word = r_key;
        end else begin
            case (nk[1:0])
                2'd0:    new_word = (agg == AGG_COUNT) ? 64'd1 : r_val;
                2'd1:    new_word = 64'd1;
                2'd2:    new_word = r_sq[63:0];
                default: new_word = r_sq[127:64];
            endcase
        end
    end

    always_comb begin
        s_we   = 1'b0;
        s_wd   = new_val;
        s_addr = {r_cpu, r_link[REC_W-1:0]};
        h_we   = 1'b0;
        h_wd   = {1'b1, wp_cur[REC_W-1:0]};
        h_addr = {r_cpu, r_hash[BKT_W-1:0]};
        case (i_cmd.op)
            OP_CLEAR: begin
                h_we   = 1'b1;
                h_wd   = '0;
                h_addr = r_cnt;
            end
            OP_KEY_RD: s_addr = {r_cpu, r_link[REC_W-1:0] + 12'd1};
            OP_VAL_RD, OP_VAL_WR: begin
                s_addr = {r_cpu, r_rec + 12'd1 + {11'b0, kw} + {10'b0, r_cnt[1:0]}};
                s_we   = (i_cmd.op == OP_VAL_WR);
            end
            OP_LINK_PREV: begin
                h_we   = r_prev_head;
                s_we   = !r_prev_head;
                s_addr = {r_cpu, r_prev};
                s_wd   = {r_hdr[63:32], 1'b1, 19'b0, wp_cur[REC_W-1:0]};
            end
            OP_NEW_WR: begin
                s_we   = 1'b1;
                s_addr = {r_cpu, r_rec + {9'b0, r_cnt[2:0]}};
                s_wd   = new_word;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_head_mem[h_addr] <= h_wd;
        end
        r_head_rd <= r_head_mem[h_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_store[s_addr] <= s_wd;
        end
        r_rdata <= r_store[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            o_strobe <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_wp[i] <= '0;
            end
        end else begin
            o_strobe <= i_cmd.emit;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.op == OP_CLEAR || i_cmd.op == OP_SQ || i_cmd.op == OP_HASH
                         || i_cmd.op == OP_VAL_WR || i_cmd.op == OP_NEW_WR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.op == OP_LINK_PREV) begin
                r_wp[r_cpu] <= wp_end[12:0];
            end
        end
    end

    assign acc_now = (i_cmd.op == OP_VAL_WR && r_cnt[1:0] == 2'd0) ? new_val : r_acc0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out.status <= i_cmd.status;
            if (i_cmd.status == ST_UPDATED || i_cmd.status == ST_CREATED) begin
                o_out.record_index      <= r_rec;
                o_out.first_accumulator <= acc_now;
            end else begin
                o_out.record_index      <= '0;
                o_out.first_accumulator <= '0;
            end
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_cpu       <= i_in.cpu_index;
                r_id        <= i_in.agg_id;
                r_key       <= i_in.key_bytes & kmask;
                r_val       <= i_in.sample_value;
                r_mag       <= i_in.sample_value[63] ? (~i_in.sample_value + 64'sd1)
                                                     : i_in.sample_value;
                r_hash      <= FNV_BASIS;
                r_prev_head <= 1'b1;
                r_prev      <= '0;
            end
            OP_SQ: begin
                case (r_cnt[1:0])
                    2'd0:    r_sq <= {64'b0, prod};
                    2'd1:    r_sq <= r_sq + ({64'b0, prod} << 33);
                    default: r_sq <= r_sq + {prod, 64'b0};
                endcase
            end
            OP_HASH:      r_hash <= (hx << FNV_PRIME_SH) + hmul;
            OP_LINK_HEAD: r_link <= {r_head_rd[12], 19'b0, r_head_rd[11:0]};
            OP_HDR_TAKE: begin
                r_hdr <= r_rdata;
                r_rec <= r_link[REC_W-1:0];
            end
            OP_NEXT: begin
                r_prev      <= r_link[REC_W-1:0];
                r_prev_head <= 1'b0;
                r_link      <= r_hdr[31:0];
            end
            OP_VAL_WR: begin
                if (r_cnt[1:0] == 2'd0) begin
                    r_acc0 <= new_val;
                end
                if (r_cnt[1:0] == 2'd2) begin
                    r_carry <= lo_sum[64];
                end
            end
            OP_LINK_PREV: begin
                r_rec  <= wp_cur[REC_W-1:0];
                r_acc0 <= (agg == AGG_COUNT) ? 64'd1 : r_val;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.bad        = (agg > AGG_STD) || (r_id[27:16] > 12'd1);
        o_stat.kw         = kw;
        o_stat.id_match   = (r_rdata[63:32] == r_id);
        o_stat.key_eq     = (r_rdata == r_key);
        o_stat.link_valid = r_link[31];
        o_stat.oversize   = (r_end > 33'(RECORD_WORDS));
        o_stat.full       = (wp_end > 14'(RECORD_WORDS));
        o_stat.sq_last    = (r_cnt[1:0] == 2'd2);
        o_stat.hash_last  = (r_cnt[2:0] == 3'd7);
        o_stat.val_last   = ({1'b0, r_cnt[1:0]} == vw - 3'd1);
        o_stat.new_last   = (r_cnt[2:0] == need - 3'd1);
        o_stat.clr_last   = (r_cnt == CNT_W'(HEAD_DEPTH - 1));
    end

endmodule

/* rtl/kaht_ctrl.sv */
// Controller: sequences clearing, squaring, hashing, chain walk, update, append and bad-word rejection
`timescale 1ns / 1ps
module kaht_ctrl
    import kaht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_SQ      = 16'h0004,
        S_HASH    = 16'h0008,
        S_HEAD_RD = 16'h0010,
        S_HEAD    = 16'h0020,
        S_CHK     = 16'h0040,
        S_HDR     = 16'h0080,
        S_KRD     = 16'h0100,
        S_KEY     = 16'h0200,
        S_NEXT    = 16'h0400,
        S_VRD     = 16'h0800,
        S_VWR     = 16'h1000,
        S_APP     = 16'h2000,
        S_NEW     = 16'h4000,
        S_SPARE   = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.cnt_clr = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.status  = ST_UPDATED;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op      = OP_LOAD;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_SQ;
                end
            end
            S_SQ: begin
                if (i_stat.bad) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_BAD;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = OP_SQ;
                    if (i_stat.sq_last) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = i_stat.kw ? S_HASH : S_HEAD_RD;
                    end
                end
            end
            S_HASH: begin
                o_cmd.op = OP_HASH;
                if (i_stat.hash_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                o_cmd.op = OP_HEAD_RD;
                n_state  = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.op = OP_LINK_HEAD;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (!i_stat.link_valid || i_stat.oversize) begin
                    n_state = S_APP;
                end else begin
                    o_cmd.op = OP_HDR_RD;
                    n_state  = S_HDR;
                end
            end
            S_HDR: begin
                o_cmd.op = OP_HDR_TAKE;
                if (!i_stat.id_match) begin
                    n_state = S_NEXT;
                end else if (i_stat.kw) begin
                    n_state = S_KRD;
                end else begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_VRD;
                end
            end
            S_KRD: begin
                o_cmd.op = OP_KEY_RD;
                n_state  = S_KEY;
            end
            S_KEY: begin
                if (i_stat.key_eq) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_VRD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.op = OP_NEXT;
                n_state  = S_CHK;
            end
            S_VRD: begin
                o_cmd.op = OP_VAL_RD;
                n_state  = S_VWR;
            end
            S_VWR: begin
                o_cmd.op = OP_VAL_WR;
                if (i_stat.val_last) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_UPDATED;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_VRD;
                end
            end
            S_APP: begin
                if (i_stat.full) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_DROPPED;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op      = OP_LINK_PREV;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_NEW;
                end
            end
            S_NEW: begin
                o_cmd.op = OP_NEW_WR;
                if (i_stat.new_last) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_CREATED;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/keyed_aggregation_hash_table_core.sv */
// Top level of the keyed aggregation hash table
`timescale 1ns / 1ps
// A word is taken on i_in at a rising edge where start is high and busy is low.
// Each accepted word gives exactly one result word on o_out, shown for one
// cycle with o_strobe high; the receiver cannot stall it.
// Each word passes through a load, the squarer (built from 32x32 multiplies),
// FNV hashing of the eight key bytes when the key is one word and a bucket
// head read, then per chain record a header read, an optional key read and a
// link step, which the record that matches skips. An update then reads and
// writes each value word; an append first sees the chain end, then writes the
// link and each record word. The result strobe is registered from the last
// step and follows in the cycle after it. Busy stays high for the whole item,
// so items are handled one at a time. The single-port record memory (one word
// read or written per cycle) sets the chain and update time. Bad type or key
// size: the loaded word is checked in the squarer state and o_strobe is
// registered from it. After reset busy stays high while all 1024 bucket head
// entries are cleared; the record memory and write pointers need no sweep.
module keyed_aggregation_hash_table_core
    import kaht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_strobe,
    output t_out_word o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    kaht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    kaht_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

/* rtl/kaht_checker.sv */
// Port-level checker for the keyed aggregation table, with its bind
`timescale 1ns / 1ps
`include "keyed_aggregation_hash_table_core_defines.svh"
module kaht_checker
    import kaht_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_word o_out
);

    logic fail_word;
    logic fail_zero;

    assign fail_word = o_strobe && (o_out.status == ST_DROPPED || o_out.status == ST_BAD);
    assign fail_zero = (o_out.record_index == 12'd0) && (o_out.first_accumulator == 64'd0);

    `KAHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !o_strobe)
    `KAHT_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe)
    `KAHT_ASSERT_NOW(a_strobe_after_busy, o_strobe, $past(busy) && !busy)
    `KAHT_ASSERT_NOW(a_fail_zero, fail_word, fail_zero)

endmodule

bind keyed_aggregation_hash_table_core kaht_checker u_kaht_checker (.*);
